### rtl/mkst_pkg.sv
// Package for the multi-kind soft timer table: sizes, transaction types,
// operation codes and the state machine encoding. No dependencies.
`timescale 1ns / 1ps
package mkst_pkg;

  localparam int ONE_SHOT_SLOTS = 8;
  localparam int PERIODIC_SLOTS = 8;
  localparam int COUNTED_SLOTS  = 8;
  localparam int TOTAL_SLOTS    = ONE_SHOT_SLOTS + PERIODIC_SLOTS + COUNTED_SLOTS;
  localparam int SLOT_W         = $clog2(TOTAL_SLOTS);

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  localparam logic [1:0] KIND_ONE_SHOT = 2'd0;
  localparam logic [1:0] KIND_PERIODIC = 2'd1;
  localparam logic [1:0] KIND_COUNTED  = 2'd2;

  localparam logic [1:0] RES_FIRED = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_NULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [23:0] delay;
    logic [15:0] count;
  } in_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] fired_kind;
    logic [7:0] fired_task;
    logic       last;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  task_id;
    logic [31:0] start;
    logic [23:0] period;
    logic [15:0] remaining;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIND,
    ST_UPDATE,
    ST_FLUSH
  } state_t;

  // Table that a slot position belongs to.
  function automatic logic [1:0] slot_kind(input logic [SLOT_W-1:0] idx);
    logic [1:0] k;
    if (idx < SLOT_W'(ONE_SHOT_SLOTS)) k = KIND_ONE_SHOT;
    else if (idx < SLOT_W'(ONE_SHOT_SLOTS + PERIODIC_SLOTS)) k = KIND_PERIODIC;
    else k = KIND_COUNTED;
    return k;
  endfunction

endpackage

### rtl/multi_kind_soft_timer_table.sv
// A tick rotates the 24 slots past the head cell, one per cycle while the
// output does not stall, then flushes; a start or stop makes one ring rotation
// to search and one to update, then flushes. Null rejections and one-firing
// counted starts go straight to the flush. One transaction is in flight at a
// time, so a new one is taken only when the last is through; output stalls hold the scan.
// Reset is synchronous: tick counter, slot valid bits and control clear.
`timescale 1ns / 1ps
module multi_kind_soft_timer_table
  import mkst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  logic              pend_v_r, pend_v_nxt;
  out_t              pend_r, pend_nxt;

  in_t               req_r, req_nxt;
  logic              mt_v_r, mt_v_nxt;
  logic [SLOT_W-1:0] mt_idx_r, mt_idx_nxt;
  logic              mt_same_r, mt_same_nxt;
  logic              fr_v_r, fr_v_nxt;
  logic [SLOT_W-1:0] fr_idx_r, fr_idx_nxt;

  slot_t cell_q [TOTAL_SLOTS];
  slot_t head, head_new;
  logic  shift;

  // Slot ring: the head cell feeds the update logic, whose result enters at the tail.
  for (genvar i = 0; i < TOTAL_SLOTS; i++) begin : g_cell
    slot_t d;
    if (i == TOTAL_SLOTS - 1) begin : g_tail
      assign d = head_new;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    mkst_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  assign head = cell_q[0];

  logic        accept, out_free, last_pos;
  logic        sel_ok, is_null, cnt_zero, cnt_one;
  logic [1:0]  head_kind;
  logic [31:0] elapsed;
  logic        due, emit_ok;
  logic        upd_restart, upd_free, upd_place, upd_full;
  logic [SLOT_W-1:0] tgt_idx;
  logic [15:0] rem_dec;
  out_t        ev;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign last_pos  = (idx_r == SLOT_W'(TOTAL_SLOTS - 1));
  assign sel_ok    = (in_data.mode == MODE_START || in_data.mode == MODE_STOP) &&
                     (in_data.kind != 2'd3);
  assign is_null   = (in_data.task_id == 8'd0);
  assign cnt_zero  = (in_data.mode == MODE_START) && (in_data.kind == KIND_COUNTED) &&
                     (in_data.count == 16'd0);
  assign cnt_one   = (in_data.mode == MODE_START) && (in_data.kind == KIND_COUNTED) &&
                     (in_data.count == 16'd1);
  assign head_kind = slot_kind(idx_r);
  assign elapsed   = tick_r - head.start;
  assign due       = head.valid && (elapsed >= {8'd0, head.period});
  assign emit_ok   = !pend_v_r || out_free;

  // Decision from the search pass.
  always_comb begin
    upd_restart = 1'b0;
    upd_free    = 1'b0;
    upd_place   = 1'b0;
    upd_full    = 1'b0;
    tgt_idx     = fr_idx_r;
    if (req_r.mode == MODE_STOP) begin
      upd_free = mt_v_r;
    end else if (req_r.kind == KIND_ONE_SHOT) begin
      if (mt_v_r) begin
        upd_restart = 1'b1;
      end else begin
        upd_place = fr_v_r;
        upd_full  = !fr_v_r;
      end
    end else if (!(mt_v_r && mt_same_r)) begin
      upd_free = mt_v_r;
      if (mt_v_r && (!fr_v_r || mt_idx_r < fr_idx_r)) tgt_idx = mt_idx_r;
      upd_place = mt_v_r || fr_v_r;
      upd_full  = !(mt_v_r || fr_v_r);
    end
  end

  always_comb begin
    unique case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
        if (accept) begin
          if (in_data.mode == MODE_TICK) state_nxt = ST_SCAN;
          else if (sel_ok && is_null) state_nxt = ST_FLUSH;
          else if (sel_ok && cnt_one) state_nxt = ST_FLUSH;
          else if (sel_ok && !cnt_zero) state_nxt = ST_FIND;
        end
      end
      ST_SCAN:   state_nxt = (last_pos && shift) ? ST_FLUSH : ST_SCAN;
      ST_FIND:   state_nxt = last_pos ? ST_UPDATE : ST_FIND;
      ST_UPDATE: state_nxt = last_pos ? ST_FLUSH : ST_UPDATE;
      ST_FLUSH:  state_nxt = (!pend_v_r || out_free) ? ST_IDLE : ST_FLUSH;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    req_nxt       = req_r;
    mt_v_nxt      = mt_v_r;
    mt_idx_nxt    = mt_idx_r;
    mt_same_nxt   = mt_same_r;
    fr_v_nxt      = fr_v_r;
    fr_idx_nxt    = fr_idx_r;
    head_new      = head;
    shift         = 1'b0;
    rem_dec       = (head.remaining != 16'd0) ? head.remaining - 16'd1 : head.remaining;
    ev            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt  = in_data;
          mt_v_nxt = 1'b0;
          fr_v_nxt = 1'b0;
          idx_nxt  = '0;
          if (in_data.mode == MODE_TICK) begin
            tick_nxt = tick_r + 32'd1;
          end else if (sel_ok && is_null) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = '{event_res: RES_NULL, fired_kind: in_data.kind,
                           fired_task: 8'd0, last: 1'b0};
          end else if (sel_ok && cnt_one) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = '{event_res: RES_FIRED, fired_kind: KIND_COUNTED,
                           fired_task: in_data.task_id, last: 1'b0};
          end
        end
      end
      ST_SCAN: begin
        shift = !due || emit_ok;
        if (due && emit_ok) begin
          ev = '{event_res: RES_FIRED, fired_kind: head_kind,
                 fired_task: head.task_id, last: 1'b0};
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pend_r;
          end
          pend_v_nxt = 1'b1;
          pend_nxt   = ev;
          if (head_kind == KIND_ONE_SHOT) begin
            head_new.valid = 1'b0;
          end else begin
            head_new.start = tick_r;
            if (head_kind == KIND_COUNTED) begin
              head_new.remaining = rem_dec;
              if (rem_dec == 16'd0) head_new.valid = 1'b0;
            end
          end
        end
        if (shift) idx_nxt = last_pos ? '0 : idx_r + SLOT_W'(1);
      end
      ST_FIND: begin
        shift   = 1'b1;
        idx_nxt = last_pos ? '0 : idx_r + SLOT_W'(1);
        if (head_kind == req_r.kind) begin
          if (!mt_v_r && head.valid && head.task_id == req_r.task_id) begin
            mt_v_nxt    = 1'b1;
            mt_idx_nxt  = idx_r;
            mt_same_nxt = (head.period == req_r.delay) &&
                          (req_r.kind != KIND_COUNTED ||
                           head.remaining == req_r.count);
          end
          if (!fr_v_r && !head.valid) begin
            fr_v_nxt   = 1'b1;
            fr_idx_nxt = idx_r;
          end
        end
      end
      ST_UPDATE: begin
        shift   = 1'b1;
        idx_nxt = last_pos ? '0 : idx_r + SLOT_W'(1);
        if (upd_restart && idx_r == mt_idx_r) head_new.start = tick_r;
        if (upd_free && idx_r == mt_idx_r) head_new.valid = 1'b0;
        if (upd_place && idx_r == tgt_idx) begin
          head_new.valid     = 1'b1;
          head_new.task_id   = req_r.task_id;
          head_new.start     = tick_r;
          // A one-shot period of one tick is stretched to two.
          head_new.period    = (req_r.kind == KIND_ONE_SHOT && req_r.delay == 24'd1) ?
                               24'd2 : req_r.delay;
          head_new.remaining = req_r.count - 16'd1;
        end
        if (last_pos) begin
          if (upd_full) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = '{event_res: RES_FULL, fired_kind: req_r.kind,
                           fired_task: req_r.task_id, last: 1'b0};
          end else if (upd_place && req_r.kind != KIND_ONE_SHOT) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = '{event_res: RES_FIRED, fired_kind: req_r.kind,
                           fired_task: req_r.task_id, last: 1'b0};
          end
        end
      end
      ST_FLUSH: begin
        // The held-back event is the final one of the transaction.
        if (pend_v_r && out_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_v_nxt        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      tick_r      <= 32'd0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      mt_v_r      <= 1'b0;
      fr_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      mt_v_r      <= mt_v_nxt;
      fr_v_r      <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_r     <= pend_nxt;
    req_r      <= req_nxt;
    mt_idx_r   <= mt_idx_nxt;
    mt_same_r  <= mt_same_nxt;
    fr_idx_r   <= fr_idx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/mkst_cell.sv
// One timer slot of the rotating slot ring.
// Depends on mkst_pkg for the slot type.
`timescale 1ns / 1ps
module mkst_cell
  import mkst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift,
  input  slot_t d,
  output slot_t q
);

  logic  valid_r;
  slot_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= d;
    end
  end

  always_comb begin
    q       = data_r;
    q.valid = valid_r;
  end

endmodule

### rtl/mkst_checker.sv
// Port-level checks for the multi-kind soft timer table, bound to the top level.
// Depends on mkst_pkg for the result type and codes.
`timescale 1ns / 1ps
module mkst_checker
  import mkst_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Error reports stand alone, so they always close their transaction.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == RES_FULL || out_data.event_res == RES_NULL)
    |-> out_data.last)
    else $error("error report not marked last");

  a_null_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == RES_NULL |-> out_data.fired_task == 8'd0)
    else $error("null rejection carries a task");

  // A fired event always names a real task.
  a_fired_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res == RES_FIRED |-> out_data.fired_task != 8'd0)
    else $error("fire event for null task");

  // Handshake signals are always resolved once out of reset.
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_valid, in_stall, out_valid}))
    else $error("handshake signal unknown");

endmodule

bind multi_kind_soft_timer_table mkst_checker u_mkst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### dv/tb_top.sv
// Testbench for the multi-kind soft timer table: directed and random start,
// stop and tick transactions checked against an in-bench timer predictor.
// Depends on mkst_pkg and the multi_kind_soft_timer_table RTL.
`timescale 1ns / 1ps
module tb_top;
  import mkst_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  multi_kind_soft_timer_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predicted timer state.
  logic [31:0] now_tick;
  logic        t_valid[TOTAL_SLOTS];
  logic [7:0]  t_task[TOTAL_SLOTS];
  logic [31:0] t_start[TOTAL_SLOTS];
  logic [23:0] t_period[TOTAL_SLOTS];
  logic [15:0] t_left[TOTAL_SLOTS];

  out_t pending_events[$];
  out_t new_events[$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  bit   sender_gaps = 1'b1;
  bit   hold_off = 1'b0;

  function automatic int base_of(logic [1:0] k);
    return (k == KIND_ONE_SHOT) ? 0 :
           (k == KIND_PERIODIC) ? ONE_SHOT_SLOTS : ONE_SHOT_SLOTS + PERIODIC_SLOTS;
  endfunction

  function automatic int size_of(logic [1:0] k);
    return (k == KIND_ONE_SHOT) ? ONE_SHOT_SLOTS :
           (k == KIND_PERIODIC) ? PERIODIC_SLOTS : COUNTED_SLOTS;
  endfunction

  function automatic int owner_slot(logic [1:0] k, logic [7:0] id);
    for (int i = base_of(k); i < base_of(k) + size_of(k); i++)
      if (t_valid[i] && t_task[i] == id) return i;
    return -1;
  endfunction

  function automatic int free_slot(logic [1:0] k);
    for (int i = base_of(k); i < base_of(k) + size_of(k); i++)
      if (!t_valid[i]) return i;
    return -1;
  endfunction

  function automatic void add_event(logic [1:0] res, logic [1:0] k, logic [7:0] id);
    out_t e;
    e.event_res = res;
    e.fired_kind = k;
    e.fired_task = id;
    e.last = 1'b0;
    new_events.push_back(e);
  endfunction

  function automatic void timer_start(in_t it);
    int s;
    logic [23:0] per;
    per = it.delay;
    if (it.task_id == 8'd0) begin
      add_event(RES_NULL, it.kind, 8'd0);
      return;
    end
    if (it.kind == KIND_ONE_SHOT) begin
      if (per == 24'd1) per = 24'd2;
      s = owner_slot(it.kind, it.task_id);
      if (s >= 0) begin
        t_start[s] = now_tick;
        return;
      end
    end else if (it.kind == KIND_PERIODIC) begin
      s = owner_slot(it.kind, it.task_id);
      if (s >= 0) begin
        if (t_period[s] == per) return;
        t_valid[s] = 1'b0;
      end
    end else begin
      if (it.count == 16'd0) return;
      if (it.count == 16'd1) begin
        add_event(RES_FIRED, KIND_COUNTED, it.task_id);
        return;
      end
      s = owner_slot(it.kind, it.task_id);
      if (s >= 0) begin
        if (t_left[s] == it.count && t_period[s] == per) return;
        t_valid[s] = 1'b0;
      end
    end
    s = free_slot(it.kind);
    if (s < 0) begin
      add_event(RES_FULL, it.kind, it.task_id);
      return;
    end
    t_valid[s] = 1'b1;
    t_task[s] = it.task_id;
    t_start[s] = now_tick;
    t_period[s] = per;
    if (it.kind == KIND_COUNTED) t_left[s] = it.count - 16'd1;
    if (it.kind != KIND_ONE_SHOT) add_event(RES_FIRED, it.kind, it.task_id);
  endfunction

  // Work out the events one accepted transaction causes and queue them.
  function automatic void predict_timer_events(in_t it);
    int s;
    logic [1:0] k;
    new_events.delete();
    if (it.mode == MODE_TICK) begin
      now_tick = now_tick + 32'd1;
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
        if (!t_valid[i] || (now_tick - t_start[i]) < {8'd0, t_period[i]}) continue;
        k = (i < ONE_SHOT_SLOTS) ? KIND_ONE_SHOT :
            (i < ONE_SHOT_SLOTS + PERIODIC_SLOTS) ? KIND_PERIODIC : KIND_COUNTED;
        add_event(RES_FIRED, k, t_task[i]);
        if (k == KIND_ONE_SHOT) t_valid[i] = 1'b0;
        else begin
          t_start[i] = now_tick;
          if (k == KIND_COUNTED) begin
            if (t_left[i] > 0) t_left[i]--;
            if (t_left[i] == 0) t_valid[i] = 1'b0;
          end
        end
      end
    end else if ((it.mode == MODE_START || it.mode == MODE_STOP) && it.kind != 2'd3) begin
      if (it.mode == MODE_START) timer_start(it);
      else if (it.task_id == 8'd0) add_event(RES_NULL, it.kind, 8'd0);
      else begin
        s = owner_slot(it.kind, it.task_id);
        if (s >= 0) t_valid[s] = 1'b0;
      end
    end
    if (new_events.size() > 0) new_events[new_events.size() - 1].last = 1'b1;
    foreach (new_events[j]) pending_events.push_back(new_events[j]);
  endfunction

  // Valid stays high from one transaction to the next unless a gap is taken.
  task automatic send_item(in_t it);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer_events(it);
  endtask

  function automatic in_t make_item(logic [1:0] m, logic [1:0] k, logic [7:0] id,
                                    logic [23:0] d, logic [15:0] c);
    in_t it;
    it.mode = m;
    it.kind = k;
    it.task_id = id;
    it.delay = d;
    it.count = c;
    return it;
  endfunction

  task automatic send_ticks(int n);
    repeat (n) send_item(make_item(MODE_TICK, 2'($urandom), 8'($urandom),
                                   24'($urandom), 16'($urandom)));
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    out_t exp_ev;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (out_data.event_res !== exp_ev.event_res) begin
          $error("event_res: expected %0d, got %0d", exp_ev.event_res, out_data.event_res);
          fail_count++;
        end
        if (out_data.fired_kind !== exp_ev.fired_kind) begin
          $error("fired_kind: expected %0d, got %0d", exp_ev.fired_kind, out_data.fired_kind);
          fail_count++;
        end
        if (out_data.fired_task !== exp_ev.fired_task) begin
          $error("fired_task: expected %0d, got %0d", exp_ev.fired_task, out_data.fired_task);
          fail_count++;
        end
        if (out_data.last !== exp_ev.last) begin
          $error("last: expected %0d, got %0d", exp_ev.last, out_data.last);
          fail_count++;
        end
      end
    end
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 7) != 0);
  end

  // Watchdog on cycles with no accepted transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("multi_kind_soft_timer_table test failed");
      $finish;
    end
  end

  task automatic test_field_extremes();
    send_item(make_item(MODE_START, KIND_ONE_SHOT, 8'd0, 24'd5, 16'd0));
    send_item(make_item(MODE_STOP, KIND_COUNTED, 8'd0, 24'd0, 16'd0));
    send_item(make_item(MODE_START, KIND_ONE_SHOT, 8'd255, 24'hFFFFFF, 16'hFFFF));
    send_item(make_item(MODE_START, KIND_ONE_SHOT, 8'd1, 24'd1, 16'd0));
    send_item(make_item(MODE_START, KIND_ONE_SHOT, 8'd2, 24'd0, 16'd0));
    send_item(make_item(MODE_START, KIND_ONE_SHOT, 8'd1, 24'd3, 16'd0));
    send_item(make_item(2'd3, KIND_ONE_SHOT, 8'd9, 24'd1, 16'd1));
    send_item(make_item(MODE_START, 2'd3, 8'd9, 24'd1, 16'd1));
    send_ticks(3);
  endtask

  task automatic test_periodic_counted();
    send_item(make_item(MODE_START, KIND_PERIODIC, 8'd10, 24'd2, 16'd0));
    send_item(make_item(MODE_START, KIND_PERIODIC, 8'd10, 24'd2, 16'd0));
    send_item(make_item(MODE_START, KIND_PERIODIC, 8'd10, 24'd3, 16'd0));
    send_item(make_item(MODE_START, KIND_COUNTED, 8'd20, 24'd1, 16'd0));
    send_item(make_item(MODE_START, KIND_COUNTED, 8'd21, 24'd1, 16'd1));
    send_item(make_item(MODE_START, KIND_COUNTED, 8'd22, 24'd1, 16'd3));
    send_item(make_item(MODE_START, KIND_COUNTED, 8'd22, 24'd1, 16'd3));
    send_item(make_item(MODE_START, KIND_COUNTED, 8'd22, 24'd2, 16'd3));
    send_ticks(5);
    send_item(make_item(MODE_STOP, KIND_PERIODIC, 8'd10, 24'd0, 16'd0));
    send_item(make_item(MODE_STOP, KIND_PERIODIC, 8'd10, 24'd0, 16'd0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < PERIODIC_SLOTS + 1; i++)
      send_item(make_item(MODE_START, KIND_PERIODIC, 8'(100 + i), 24'hFFFFF0, 16'd0));
    for (int i = 0; i < PERIODIC_SLOTS; i++)
      send_item(make_item(MODE_STOP, KIND_PERIODIC, 8'(100 + i), 24'd0, 16'd0));
  endtask

  // Receiver holds off while the sender keeps offering transactions.
  task automatic test_backpressure();
    hold_off = 1'b1;
    sender_gaps = 1'b0;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++)
          send_item(make_item(MODE_START, KIND_PERIODIC, 8'(40 + i), 24'd1, 16'd0));
        send_ticks(4);
      end
    join
    sender_gaps = 1'b1;
    for (int i = 0; i < 8; i++)
      send_item(make_item(MODE_STOP, KIND_PERIODIC, 8'(40 + i), 24'd0, 16'd0));
  endtask

  task automatic test_random_traffic(int n);
    in_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      it = in_t'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      // Mostly ticks and well-formed starts and stops on a small task set.
      if (r < 40) it.mode = MODE_TICK;
      else if (r < 75) it.mode = MODE_START;
      else if (r < 95) it.mode = MODE_STOP;
      if (r < 95) begin
        it.kind = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 19) != 0) it.task_id = 8'($urandom_range(1, 12));
        if ($urandom_range(0, 9) != 0) it.delay = 24'($urandom_range(0, 6));
        if ($urandom_range(0, 9) != 0) it.count = 16'($urandom_range(0, 5));
      end
      if (r >= 40 && r < 95 && $urandom_range(0, 31) == 0) it.task_id = 8'd255;
      send_item(it);
    end
  endtask

  initial begin
    now_tick = '0;
    foreach (t_valid[i]) begin
      t_valid[i] = 1'b0;
      t_task[i] = '0;
      t_start[i] = '0;
      t_period[i] = '0;
      t_left[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_periodic_counted();
    test_table_full();
    test_backpressure();
    test_random_traffic(300);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4 * TOTAL_SLOTS) @(posedge clk);
    if (fail_count == 0) $display("multi_kind_soft_timer_table test passed");
    else $display("multi_kind_soft_timer_table test failed");
    $finish;
  end
endmodule
